FILE: hw/rtl/pmc_pkg.sv
package pmc_pkg;

    localparam int MAX_MATCHES_DEF = 64;
    localparam int RESULT_CAP      = 64;
    localparam int COORD_W         = 16;
    localparam int ANGLE_W         = 13;
    localparam int INDEX_W         = 6;
    localparam int DELTA_W         = 17;
    localparam int DIR_W           = 14;
    localparam int CHUNK_W         = 8;
    localparam int CORDIC_ITERS    = 16;

    localparam logic [ANGLE_W-1:0] TOL_RESET = 13'd160;

    // direction angles in sixteenths of a degree
    localparam logic signed [DIR_W-1:0] DIR_UP    = 14'sd1440;
    localparam logic signed [DIR_W-1:0] DIR_DOWN  = 14'sd4320;
    localparam logic signed [DIR_W-1:0] HALF_TURN = 14'sd2880;
    localparam logic [12:0]             PHI_MAX   = 13'd1440;

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [DIR_W-1:0]   dir_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ANGLE_W-1:0] a;
    } point_t;

    typedef struct packed {
        point_t q;
        point_t t;
    } match_t;

    typedef struct packed {
        logic   start;
        delta_t dx;
        delta_t dy;
    } cordic_req_t;

    typedef struct packed {
        logic done;
        dir_t dir;
    } cordic_rsp_t;

    // arctangent of 2^-i in 1/4096 degree
    function automatic logic [17:0] cordic_atan(input logic [3:0] i);
        logic [17:0] v;
        case (i)
            4'd0:    v = 18'd184320;
            4'd1:    v = 18'd108810;
            4'd2:    v = 18'd57492;
            4'd3:    v = 18'd29184;
            4'd4:    v = 18'd14649;
            4'd5:    v = 18'd7331;
            4'd6:    v = 18'd3667;
            4'd7:    v = 18'd1833;
            4'd8:    v = 18'd917;
            4'd9:    v = 18'd458;
            4'd10:   v = 18'd229;
            4'd11:   v = 18'd115;
            4'd12:   v = 18'd57;
            4'd13:   v = 18'd29;
            4'd14:   v = 18'd14;
            default: v = 18'd7;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] pop_chunk(input logic [CHUNK_W-1:0] v);
        logic [3:0] c;
        c = '0;
        for (int b = 0; b < CHUNK_W; b++) begin
            c = c + {3'b0, v[b]};
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/pmc_cordic.sv
module pmc_cordic
    import pmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    localparam int XW = 27;
    localparam int ZW = 21;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_ITER = 3'b010,
        C_FIN  = 3'b100
    } cstate_t;

    cstate_t state_reg, state_next;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [3:0] it_reg, it_next;
    logic xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic done_reg, done_next;
    dir_t dir_reg, dir_next;

    delta_t ndx, ndy;
    logic [COORD_W-1:0] ax, ay;
    logic signed [XW-1:0] xs, yabs, ys_mag, ys;
    logic signed [ZW-1:0] atan_s, zc, zs;
    logic [12:0] rnd;
    logic [11:0] phi;
    dir_t phi_s;

    always_comb begin
        ndx    = -req.dx;
        ndy    = -req.dy;
        ax     = req.dx[DELTA_W-1] ? ndx[COORD_W-1:0] : req.dx[COORD_W-1:0];
        ay     = req.dy[DELTA_W-1] ? ndy[COORD_W-1:0] : req.dy[COORD_W-1:0];
        xs     = x_reg >>> it_reg;
        yabs   = y_reg[XW-1] ? -y_reg : y_reg;
        ys_mag = yabs >>> it_reg;
        // truncate toward zero for a negative y
        ys     = y_reg[XW-1] ? -ys_mag : ys_mag;
        atan_s = signed'({3'b000, cordic_atan(it_reg)});
        zc     = z_reg[ZW-1] ? '0 : z_reg;
        zs     = zc + ZW'(128);
        rnd    = zs[20:8];
        phi    = (rnd > PHI_MAX) ? PHI_MAX[11:0] : rnd[11:0];
        phi_s  = signed'({2'b00, phi});
    end

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        it_next    = it_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        done_next  = 1'b0;
        dir_next   = dir_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (req.start) begin
                    xneg_next = req.dx[DELTA_W-1];
                    yneg_next = req.dy[DELTA_W-1];
                    x_next    = signed'({3'b000, ax, 8'h00});
                    y_next    = signed'({3'b000, ay, 8'h00});
                    z_next    = '0;
                    it_next   = '0;
                    if (req.dx == '0) begin
                        dir_next  = req.dy[DELTA_W-1] ? DIR_DOWN : DIR_UP;
                        done_next = 1'b1;
                    end else if (ay == '0) begin
                        state_next = C_FIN;
                    end else begin
                        state_next = C_ITER;
                    end
                end
            end
            C_ITER: begin
                if (!y_reg[XW-1]) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_s;
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_s;
                end
                it_next = it_reg + 4'd1;
                if (it_reg == 4'(CORDIC_ITERS - 1)) begin
                    state_next = C_FIN;
                end
            end
            C_FIN: begin
                if (!xneg_reg) begin
                    dir_next = yneg_reg ? -phi_s : phi_s;
                end else begin
                    dir_next = yneg_reg ? (phi_s - HALF_TURN) : (HALF_TURN - phi_s);
                end
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        it_reg   <= it_next;
        xneg_reg <= xneg_next;
        yneg_reg <= yneg_next;
        dir_reg  <= dir_next;
    end

    assign rsp.done = done_reg;
    assign rsp.dir  = dir_reg;

endmodule

FILE: hw/rtl/pairwise_match_consistency_filter_unit.sv
// Pairwise match consistency filter. Matches stream in on the s_ channel, one transaction
// each; the transaction flagged by s_last_match closes the set and starts the greedy
// selection, whose picks leave on the m_ channel (the final one flagged by m_last_result,
// or a single transaction with m_inlier_valid low when nothing qualifies). Loading match n
// checks it against the n earlier matches, each check running two 16-step arctangents on
// one shared CORDIC unit; s_ready stays low meanwhile.
// Each selection round steps through every loaded index, skipping a dropped candidate
// and reading the consistency row of a live one, which is counted 8 bits per cycle,
// plus a mask update per pick. Loading dominates. cfg_wdata sets the angle tolerance
// (1/16 degree, strict) and is to be written only while the block is idle.
module pairwise_match_consistency_filter_unit
    import pmc_pkg::*;
#(
    parameter int MAX_MATCHES = MAX_MATCHES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [ANGLE_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_query_x,
    input  logic [COORD_W-1:0] s_query_y,
    input  logic [ANGLE_W-1:0] s_query_angle,
    input  logic [COORD_W-1:0] s_train_x,
    input  logic [COORD_W-1:0] s_train_y,
    input  logic [ANGLE_W-1:0] s_train_angle,
    input  logic               s_last_match,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_match_index,
    output logic               m_inlier_valid,
    output logic               m_last_result
);

    localparam int IDX_W  = $clog2(MAX_MATCHES);
    localparam int CNT_W  = $clog2(MAX_MATCHES + 1);
    localparam int NCHUNK = (MAX_MATCHES + CHUNK_W - 1) / CHUNK_W;
    localparam int ROW_W  = NCHUNK * CHUNK_W;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PICK_W = $clog2(RESULT_CAP + 1);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PRD   = 14'b00000000000010,
        S_PQS   = 14'b00000000000100,
        S_PQW   = 14'b00000000001000,
        S_PTS   = 14'b00000000010000,
        S_PTW   = 14'b00000000100000,
        S_LWR   = 14'b00000001000000,
        S_SINIT = 14'b00000010000000,
        S_SCHK  = 14'b00000100000000,
        S_SCNT  = 14'b00001000000000,
        S_SDEC  = 14'b00010000000000,
        S_SPICK = 14'b00100000000000,
        S_SMUPD = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next, scan_reg, scan_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [CH_W-1:0] chunk_reg, chunk_next;
    logic have_best_reg, have_best_next, have_pend_reg, have_pend_next;
    logic [PICK_W-1:0] npick_reg, npick_next;
    logic out_valid_reg, out_valid_next;
    logic [ANGLE_W-1:0] tol_reg, tol_next;

    match_t new_reg, new_next;
    logic last_reg, last_next;
    dir_t dirq_reg, dirq_next;
    logic [MAX_MATCHES-1:0] rowvec_reg, rowvec_next, mask_reg, mask_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, best_cnt_reg, best_cnt_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next, pend_reg, pend_next;
    logic [IDX_W-1:0] em_idx_reg, em_idx_next;
    logic em_valid_reg, em_valid_next, em_last_reg, em_last_next;
    logic [INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic out_inl_reg, out_inl_next, out_last_reg, out_last_next;

    // memories
    match_t pts_mem [MAX_MATCHES];
    logic [MAX_MATCHES-1:0] row_mem [MAX_MATCHES];
    match_t pts_rd_reg;
    logic [MAX_MATCHES-1:0] row_rd_reg;
    logic rd_en, row_we, pts_we;
    logic [IDX_W-1:0] rd_addr, row_wa;
    logic [MAX_MATCHES-1:0] row_wd;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    logic [IDX_W-1:0] n_idx;
    logic out_free, pair_bit;
    delta_t d1, thq, tht, d2, a1, a2;
    logic [ROW_W-1:0] row_pad;
    logic [CHUNK_W-1:0] chunk_bits;
    logic [CNT_W-1:0] sum;
    logic [IDX_W+INDEX_W-1:0] em_idx_wide;

    pmc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    assign n_idx    = loaded_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        d1  = (delta_t'(pts_rd_reg.q.a) - delta_t'(new_reg.q.a))
            - (delta_t'(pts_rd_reg.t.a) - delta_t'(new_reg.t.a));
        thq = {{(DELTA_W-DIR_W){dirq_reg[DIR_W-1]}}, dirq_reg} - delta_t'(pts_rd_reg.q.a);
        tht = {{(DELTA_W-DIR_W){crsp.dir[DIR_W-1]}}, crsp.dir} - delta_t'(pts_rd_reg.t.a);
        d2  = thq - tht;
        a1  = d1[DELTA_W-1] ? -d1 : d1;
        a2  = d2[DELTA_W-1] ? -d2 : d2;
        pair_bit = (a1 < delta_t'(tol_reg)) && (a2 < delta_t'(tol_reg));
    end

    always_comb begin
        row_pad = '0;
        row_pad[MAX_MATCHES-1:0] = row_rd_reg & mask_reg;
        chunk_bits = row_pad[chunk_reg*CHUNK_W +: CHUNK_W];
        sum = cnt_reg + CNT_W'(pop_chunk(chunk_bits));
    end

    always_comb begin
        creq.start = (state_reg == S_PQS) || (state_reg == S_PTS);
        if (state_reg == S_PTS) begin
            creq.dx = delta_t'(new_reg.t.x) - delta_t'(pts_rd_reg.t.x);
            creq.dy = delta_t'(new_reg.t.y) - delta_t'(pts_rd_reg.t.y);
        end else begin
            creq.dx = delta_t'(new_reg.q.x) - delta_t'(pts_rd_reg.q.x);
            creq.dy = delta_t'(new_reg.q.y) - delta_t'(pts_rd_reg.q.y);
        end
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        loaded_next    = loaded_reg;
        scan_next      = scan_reg;
        k_next         = k_reg;
        chunk_next     = chunk_reg;
        have_best_next = have_best_reg;
        have_pend_next = have_pend_reg;
        npick_next     = npick_reg;
        tol_next       = cfg_we ? cfg_wdata : tol_reg;
        new_next       = new_reg;
        last_next      = last_reg;
        dirq_next      = dirq_reg;
        rowvec_next    = rowvec_reg;
        mask_next      = mask_reg;
        cnt_next       = cnt_reg;
        best_cnt_next  = best_cnt_reg;
        best_idx_next  = best_idx_reg;
        pend_next      = pend_reg;
        em_idx_next    = em_idx_reg;
        em_valid_next  = em_valid_reg;
        em_last_next   = em_last_reg;
        rd_en          = 1'b0;
        rd_addr        = k_reg;
        row_we         = 1'b0;
        pts_we         = 1'b0;
        row_wa         = k_reg;
        row_wd         = row_rd_reg;
        out_valid_next = out_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    new_next    = '{q: '{x: s_query_x, y: s_query_y, a: s_query_angle},
                                    t: '{x: s_train_x, y: s_train_y, a: s_train_angle}};
                    last_next   = s_last_match;
                    rowvec_next = '0;
                    k_next      = '0;
                    if (loaded_reg < CNT_W'(MAX_MATCHES)) begin
                        state_next = (loaded_reg == '0) ? S_LWR : S_PRD;
                    end else begin
                        // set is full: drop the match but honor its last flag
                        state_next = s_last_match ? S_SINIT : S_IDLE;
                    end
                end
            end
            S_PRD: begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = S_PQS;
            end
            S_PQS: state_next = S_PQW;
            S_PQW: begin
                if (crsp.done) begin
                    dirq_next  = crsp.dir;
                    state_next = S_PTS;
                end
            end
            S_PTS: state_next = S_PTW;
            S_PTW: begin
                if (crsp.done) begin
                    // read-modify-write: set column n in earlier row k
                    row_we             = 1'b1;
                    row_wa             = k_reg;
                    row_wd             = row_rd_reg;
                    row_wd[n_idx]      = pair_bit;
                    rowvec_next[k_reg] = pair_bit;
                    if (CNT_W'(k_reg) + CNT_W'(1) == loaded_reg) begin
                        state_next = S_LWR;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_PRD;
                    end
                end
            end
            S_LWR: begin
                row_we      = 1'b1;
                pts_we      = 1'b1;
                row_wa      = n_idx;
                row_wd      = rowvec_reg;
                loaded_next = loaded_reg + CNT_W'(1);
                state_next  = last_reg ? S_SINIT : S_IDLE;
            end
            S_SINIT: begin
                for (int b = 0; b < MAX_MATCHES; b++) begin
                    mask_next[b] = (CNT_W'(b) < loaded_reg);
                end
                scan_next      = '0;
                have_best_next = 1'b0;
                have_pend_next = 1'b0;
                npick_next     = '0;
                state_next     = S_SCHK;
            end
            S_SCHK: begin
                if (scan_reg == loaded_reg) begin
                    state_next = S_SDEC;
                end else if (mask_reg[scan_reg[IDX_W-1:0]]) begin
                    rd_en      = 1'b1;
                    rd_addr    = scan_reg[IDX_W-1:0];
                    cnt_next   = '0;
                    chunk_next = '0;
                    state_next = S_SCNT;
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            S_SCNT: begin
                if (chunk_reg == CH_W'(NCHUNK - 1)) begin
                    // strict compare keeps the earliest of equal counts
                    if (!have_best_reg || (sum > best_cnt_reg)) begin
                        best_cnt_next  = sum;
                        best_idx_next  = scan_reg[IDX_W-1:0];
                        have_best_next = 1'b1;
                    end
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = S_SCHK;
                end else begin
                    cnt_next   = sum;
                    chunk_next = chunk_reg + CH_W'(1);
                end
            end
            S_SDEC: begin
                if (have_best_reg && (best_cnt_reg != '0)) begin
                    if (have_pend_reg) begin
                        em_idx_next   = pend_reg;
                        em_valid_next = 1'b1;
                        em_last_next  = 1'b0;
                        ret_next      = S_SPICK;
                        state_next    = S_EMIT;
                    end else begin
                        state_next = S_SPICK;
                    end
                end else begin
                    em_idx_next   = have_pend_reg ? pend_reg : '0;
                    em_valid_next = have_pend_reg;
                    em_last_next  = 1'b1;
                    loaded_next   = '0;
                    ret_next      = S_IDLE;
                    state_next    = S_EMIT;
                end
            end
            S_SPICK: begin
                pend_next      = best_idx_reg;
                have_pend_next = 1'b1;
                npick_next     = npick_reg + PICK_W'(1);
                if (npick_reg + PICK_W'(1) == PICK_W'(RESULT_CAP)) begin
                    em_idx_next   = best_idx_reg;
                    em_valid_next = 1'b1;
                    em_last_next  = 1'b1;
                    loaded_next   = '0;
                    ret_next      = S_IDLE;
                    state_next    = S_EMIT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = best_idx_reg;
                    state_next = S_SMUPD;
                end
            end
            S_SMUPD: begin
                // keep only partners of the pick
                mask_next      = mask_reg & row_rd_reg;
                scan_next      = '0;
                have_best_next = 1'b0;
                state_next     = S_SCHK;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ret_reg;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign em_idx_wide = {{INDEX_W{1'b0}}, em_idx_reg};

    always_comb begin
        out_idx_next  = out_idx_reg;
        out_inl_next  = out_inl_reg;
        out_last_next = out_last_reg;
        if ((state_reg == S_EMIT) && out_free) begin
            out_idx_next  = em_idx_wide[INDEX_W-1:0];
            out_inl_next  = em_valid_reg;
            out_last_next = em_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            loaded_reg    <= '0;
            scan_reg      <= '0;
            k_reg         <= '0;
            chunk_reg     <= '0;
            have_best_reg <= 1'b0;
            have_pend_reg <= 1'b0;
            npick_reg     <= '0;
            out_valid_reg <= 1'b0;
            tol_reg       <= TOL_RESET;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            loaded_reg    <= loaded_next;
            scan_reg      <= scan_next;
            k_reg         <= k_next;
            chunk_reg     <= chunk_next;
            have_best_reg <= have_best_next;
            have_pend_reg <= have_pend_next;
            npick_reg     <= npick_next;
            out_valid_reg <= out_valid_next;
            tol_reg       <= tol_next;
        end
    end

    always_ff @(posedge aclk) begin
        new_reg      <= new_next;
        last_reg     <= last_next;
        dirq_reg     <= dirq_next;
        rowvec_reg   <= rowvec_next;
        mask_reg     <= mask_next;
        cnt_reg      <= cnt_next;
        best_cnt_reg <= best_cnt_next;
        best_idx_reg <= best_idx_next;
        pend_reg     <= pend_next;
        em_idx_reg   <= em_idx_next;
        em_valid_reg <= em_valid_next;
        em_last_reg  <= em_last_next;
        out_idx_reg  <= out_idx_next;
        out_inl_reg  <= out_inl_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_wa] <= row_wd;
        end
        if (rd_en) begin
            row_rd_reg <= row_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pts_we) begin
            pts_mem[n_idx] <= new_reg;
        end
        if (rd_en) begin
            pts_rd_reg <= pts_mem[rd_addr];
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_match_index  = out_idx_reg;
    assign m_inlier_valid = out_inl_reg;
    assign m_last_result  = out_last_reg;

endmodule

FILE: hw/rtl/pmc_checker.sv
module pmc_checker
    import pmc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [INDEX_W-1:0] m_match_index,
    input logic               m_inlier_valid,
    input logic               m_last_result
);

    // a stalled result transaction holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_index)
            && $stable(m_inlier_valid) && $stable(m_last_result))
        else $error("result transaction changed while stalled");

    // an empty pick closes the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inlier_valid |-> m_last_result)
        else $error("empty result not marked last");

    // an empty pick carries index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inlier_valid |-> m_match_index == '0)
        else $error("empty result with nonzero index");

    // no result comes out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pairwise_match_consistency_filter_unit pmc_checker u_pmc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_match_index  (m_match_index),
    .m_inlier_valid (m_inlier_valid),
    .m_last_result  (m_last_result)
);
